// ----- rtl/vre_pkg.sv -----
// Shared types, constants and helper functions for the voice radio effect block.
// No dependencies; every other file imports this package.
package vre_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int DS_W       = 8;
  localparam int CHAN_W     = 2;
  localparam int LEVEL_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ABS_W      = SAMPLE_W + 1;
  localparam int SAT_IN_W   = 24;
  localparam int LFSR_W     = 32;

  localparam int MAX_CHANNELS_DEF = 2;
  localparam int BLOCK_MAX_DEF    = 4096;
  localparam int LEVEL_CLAMP_DEF  = 1800;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;
  localparam logic [LFSR_W-1:0] LFSR_MASK  = 32'hD000_0001;
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 32'h0000_ACE1;

  localparam logic signed [SAT_IN_W-1:0] SAT_HI = 24'sd32767;
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -24'sd32768;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_MUTE,
    MODE_PLAIN,
    MODE_RADIO
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE,
    REG_CHANNEL_COUNT,
    REG_CLIENT_GAIN,
    REG_DISTORTION_LIMIT,
    REG_RADIO_GAIN,
    REG_NOISE_GAIN,
    REG_DOWNSAMPLE
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PROD,
    ST_HOLD,
    ST_WAIT
  } top_state_t;

  typedef enum logic [1:0] {
    LV_IDLE,
    LV_DEN,
    LV_RUN
  } lvl_state_t;

  typedef struct packed {
    logic start;
    logic stage_a;
    logic stage_b;
    logic stage_h;
  } radio_ctl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7FFF;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ABS_W-1:0] abs17(input logic signed [SAMPLE_W-1:0] x);
    logic [ABS_W-1:0] e;
    e = {x[SAMPLE_W-1], x};
    return x[SAMPLE_W-1] ? (~e + 17'd1) : e;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    return v[0] ? (s ^ LFSR_MASK) : s;
  endfunction

endpackage

// ----- rtl/voice_radio_effect_level_top.sv -----
// An accepted request steps through the MUL, PROD, HOLD and WAIT states to a valid result; on
// a block-end frame that reports a level, WAIT also holds for the denominator step and the
// 17-step restoring divider in vre_level. One request is in flight at a time; a finished
// result waits in the output register while the next request is taken.
// Reset: synchronous active-low rst_n restores register defaults, clears phase, level
// accumulators and held radio values, and reseeds the noise LFSR.
module voice_radio_effect_level_top
  import vre_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
  parameter int BLOCK_MAX    = BLOCK_MAX_DEF,
  parameter int LEVEL_CLAMP  = LEVEL_CLAMP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample_left,
  input  logic signed [SAMPLE_W-1:0]  in_sample_right,
  input  logic                        in_block_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_left,
  output logic signed [SAMPLE_W-1:0]  out_right,
  output logic [LEVEL_W-1:0]          out_level,
  output logic                        out_block_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int MAG_W = $clog2(LEVEL_CLAMP + 1);

  top_state_t                  state_r, state_nxt;

  mode_t                       cfg_mode_r;
  logic [CHAN_W-1:0]           cfg_chan_r;
  logic [GAIN_W-1:0]           cfg_client_gain_r;
  logic [LIMIT_W-1:0]          cfg_limit_r;
  logic [GAIN_W-1:0]           cfg_radio_gain_r;
  logic [GAIN_W-1:0]           cfg_noise_gain_r;
  logic [DS_W-1:0]             cfg_ds_r;

  logic signed [SAMPLE_W-1:0]  x_r [MAX_CHANNELS];
  logic                        last_r;
  logic                        odd_r;
  logic [DS_W-1:0]             phase_r;

  logic                        out_valid_r;
  logic signed [SAMPLE_W-1:0]  out_left_r;
  logic signed [SAMPLE_W-1:0]  out_right_r;
  logic [LEVEL_W-1:0]          out_level_r;
  logic                        out_block_last_r;

  logic                        accept;
  logic                        out_load;
  logic                        gain_ok;
  logic                        lvl_en;
  logic                        two_ch;
  logic [DS_W-1:0]             factor;
  logic [DS_W-1:0]             phase_eff;
  logic [DS_W:0]               phase_inc;
  logic [DS_W-1:0]             phase_nxt;
  logic                        grp_start;
  logic [ABS_W-1:0]            xl_abs;
  logic [MAG_W-1:0]            mag;
  radio_ctl_t                  rctl;
  logic signed [SAMPLE_W-1:0]  held_clean;
  logic signed [SAMPLE_W-1:0]  held_noisy;
  logic signed [SAMPLE_W-1:0]  radio_val;
  logic signed [SAMPLE_W-1:0]  lane_out [MAX_CHANNELS];
  logic signed [SAMPLE_W-1:0]  lane_in [MAX_CHANNELS];
  logic                        lvl_busy;
  logic [LEVEL_W-1:0]          lvl_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r        <= MODE_PASS;
      cfg_chan_r        <= CHAN_W'(1);
      cfg_client_gain_r <= GAIN_UNITY;
      cfg_limit_r       <= 15'h7FFF;
      cfg_radio_gain_r  <= 16'h1000;
      cfg_noise_gain_r  <= '0;
      cfg_ds_r          <= DS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:             cfg_mode_r        <= mode_t'(cfg_data[1:0]);
        REG_CHANNEL_COUNT:    cfg_chan_r        <= cfg_data[CHAN_W-1:0];
        REG_CLIENT_GAIN:      cfg_client_gain_r <= cfg_data[GAIN_W-1:0];
        REG_DISTORTION_LIMIT: cfg_limit_r       <= cfg_data[LIMIT_W-1:0];
        REG_RADIO_GAIN:       cfg_radio_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_NOISE_GAIN:       cfg_noise_gain_r  <= cfg_data[GAIN_W-1:0];
        REG_DOWNSAMPLE:       cfg_ds_r          <= cfg_data[DS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept  = in_valid && in_ready;
  assign gain_ok = (cfg_client_gain_r != '0) && (cfg_client_gain_r <= GAIN_UNITY);
  assign lvl_en  = gain_ok && (cfg_mode_r == MODE_PLAIN || cfg_mode_r == MODE_RADIO);
  // zero channels acts as one, three as two
  assign two_ch  = (MAX_CHANNELS > 1) && cfg_chan_r[1];

  // a phase left past a lowered factor opens a new group
  assign factor    = (cfg_ds_r == '0) ? DS_W'(1) : cfg_ds_r;
  assign phase_eff = (phase_r >= factor) ? '0 : phase_r;
  assign phase_inc = {1'b0, phase_eff} + (DS_W+1)'(1);
  assign phase_nxt = (in_block_end || phase_inc >= {1'b0, factor}) ? '0 : phase_inc[DS_W-1:0];
  assign grp_start = (cfg_mode_r == MODE_RADIO) && gain_ok && (phase_eff == '0);

  assign xl_abs = abs17(in_sample_left);
  assign mag    = (xl_abs > ABS_W'(LEVEL_CLAMP)) ? MAG_W'(LEVEL_CLAMP) : xl_abs[MAG_W-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_HOLD;
      ST_HOLD: state_nxt = ST_WAIT;
      ST_WAIT: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state_r == ST_IDLE);
    rctl.start   = accept && grp_start;
    rctl.stage_a = (state_r == ST_MUL);
    rctl.stage_b = (state_r == ST_PROD);
    rctl.stage_h = (state_r == ST_HOLD);
    // hold the result until the level divider finishes and the output slot frees
    out_load     = (state_r == ST_WAIT) && !lvl_busy && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        phase_r <= phase_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign lane_in[0] = in_sample_left;
  if (MAX_CHANNELS > 1) begin : g_right_in
    assign lane_in[MAX_CHANNELS-1] = in_sample_right;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= lane_in;
      last_r <= in_block_end;
      odd_r  <= phase_eff[0];
    end
    if (out_load) begin
      out_left_r       <= lane_out[0];
      out_right_r      <= two_ch ? lane_out[MAX_CHANNELS-1] : '0;
      out_level_r      <= lvl_value;
      out_block_last_r <= last_r;
    end
  end

  vre_radio u_radio (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (rctl),
    .sample           (x_r[0]),
    .distortion_limit (cfg_limit_r),
    .radio_gain       (cfg_radio_gain_r),
    .client_gain      (cfg_client_gain_r),
    .noise_gain       (cfg_noise_gain_r),
    .held_clean       (held_clean),
    .held_noisy       (held_noisy)
  );

  assign radio_val = odd_r ? held_noisy : held_clean;

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    vre_lane u_lane (
      .clk         (clk),
      .load        (rctl.stage_a),
      .sample      (x_r[g]),
      .client_gain (cfg_client_gain_r),
      .mode        (cfg_mode_r),
      .gain_ok     (gain_ok),
      .radio_val   (radio_val),
      .lane_out    (lane_out[g])
    );
  end

  vre_level #(
    .BLOCK_MAX   (BLOCK_MAX),
    .LEVEL_CLAMP (LEVEL_CLAMP)
  ) u_level (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_en (accept),
    .mag    (mag),
    .last   (in_block_end),
    .lvl_en (lvl_en),
    .busy   (lvl_busy),
    .level  (lvl_value)
  );

  assign out_valid      = out_valid_r;
  assign out_left       = out_left_r;
  assign out_right      = out_right_r;
  assign out_level      = out_level_r;
  assign out_block_last = out_block_last_r;

`ifndef SYNTH
  a_level_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_level != '0 |-> out_block_last)
    else $error("level reported on a frame that does not end a block");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_MUL)
    else $error("accepted request did not enter the multiply stage");

  a_divider_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_busy |-> state_r != ST_IDLE)
    else $error("level divider running with no request in flight");

  a_single_channel_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && !two_ch |=> out_right == '0)
    else $error("right channel not zeroed in single channel use");
`endif

endmodule

// ----- rtl/vre_lane.sv -----
// One channel lane: plain gain scaling with saturation and per-mode output select.
// Depends on vre_pkg.
module vre_lane
  import vre_pkg::*;
(
  input  logic                       clk,
  input  logic                       load,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [GAIN_W-1:0]          client_gain,
  input  mode_t                      mode,
  input  logic                       gain_ok,
  input  logic signed [SAMPLE_W-1:0] radio_val,
  output logic signed [SAMPLE_W-1:0] lane_out
);

  localparam int PROD_W = ABS_W + GAIN_W;

  logic [PROD_W-1:0]            prod_r;
  logic                         neg_r;
  logic [PROD_W-16:0]           quo;
  logic signed [SAT_IN_W-1:0]   scaled_w;
  logic signed [SAMPLE_W-1:0]   plain;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= {{GAIN_W{1'b0}}, abs17(sample)} * {{ABS_W{1'b0}}, client_gain};
      neg_r  <= sample[SAMPLE_W-1];
    end
  end

  // Q1.15 product, truncated toward zero
  assign quo      = prod_r[PROD_W-1:15];
  assign scaled_w = neg_r ? -$signed({6'b0, quo}) : $signed({6'b0, quo});
  assign plain    = sat16(scaled_w);

  always_comb begin
    case (mode)
      MODE_PASS:  lane_out = sample;
      MODE_MUTE:  lane_out = '0;
      MODE_PLAIN: lane_out = gain_ok ? plain : sample;
      MODE_RADIO: lane_out = gain_ok ? radio_val : sample;
      default:    lane_out = sample;
    endcase
  end

endmodule

// ----- rtl/vre_radio.sv -----
// Radio core on channel 0: clip, two-gain scale, noise LFSR and held clean/noisy pair.
// Depends on vre_pkg.
module vre_radio
  import vre_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  radio_ctl_t                 ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [LIMIT_W-1:0]         distortion_limit,
  input  logic [GAIN_W-1:0]          radio_gain,
  input  logic [GAIN_W-1:0]          client_gain,
  input  logic [GAIN_W-1:0]          noise_gain,
  output logic signed [SAMPLE_W-1:0] held_clean,
  output logic signed [SAMPLE_W-1:0] held_noisy
);

  localparam int GPROD_W = 2 * GAIN_W;
  localparam int MPROD_W = LIMIT_W + GPROD_W;
  localparam int NPROD_W = ABS_W + GAIN_W;

  logic [LFSR_W-1:0]            lfsr_r;
  logic                         start_r;
  logic [GPROD_W-1:0]           gprod_r;
  logic [LIMIT_W-1:0]           cmag_r;
  logic                         cneg_r;
  logic [NPROD_W-1:0]           nprod_r;
  logic                         nneg_r;
  logic [MPROD_W-1:0]           mprod_r;
  logic signed [SAMPLE_W-1:0]   held_clean_r;
  logic signed [SAMPLE_W-1:0]   held_noisy_r;

  logic [ABS_W-1:0]             xabs;
  logic [LIMIT_W-1:0]           cmag;
  logic signed [SAMPLE_W-1:0]   noise;
  logic [MPROD_W-28:0]          cq;
  logic [NPROD_W-17:0]          nq;
  logic signed [SAT_IN_W-1:0]   clean_w;
  logic signed [SAT_IN_W-1:0]   nq_s;
  logic signed [SAT_IN_W-1:0]   noisy_w;
  logic signed [SAMPLE_W-1:0]   clean;

  assign xabs  = abs17(sample);
  assign cmag  = (xabs > {2'b0, distortion_limit}) ? distortion_limit : xabs[LIMIT_W-1:0];
  assign noise = lfsr_r[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r       <= LFSR_SEED;
      start_r      <= 1'b0;
      held_clean_r <= '0;
      held_noisy_r <= '0;
    end else begin
      if (ctl.start) begin
        lfsr_r <= lfsr_step(lfsr_r);
      end
      // hold the group-start mark until the held pair is written
      if (ctl.stage_h || ctl.start) begin
        start_r <= ctl.start;
      end
      if (ctl.stage_h && start_r) begin
        held_clean_r <= clean;
        held_noisy_r <= sat16(noisy_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.stage_a) begin
      gprod_r <= {{GAIN_W{1'b0}}, radio_gain} * {{GAIN_W{1'b0}}, client_gain};
      cmag_r  <= cmag;
      cneg_r  <= sample[SAMPLE_W-1];
      nprod_r <= {{GAIN_W{1'b0}}, abs17(noise)} * {{ABS_W{1'b0}}, noise_gain};
      nneg_r  <= noise[SAMPLE_W-1];
    end
    if (ctl.stage_b) begin
      mprod_r <= {{GPROD_W{1'b0}}, cmag_r} * {{LIMIT_W{1'b0}}, gprod_r};
    end
  end

  // Q4.12 times Q1.15 leaves 27 fraction bits; noise gain is Q0.16
  assign cq      = mprod_r[MPROD_W-1:27];
  assign clean_w = cneg_r ? -$signed({4'b0, cq}) : $signed({4'b0, cq});
  assign clean   = sat16(clean_w);
  assign nq      = nprod_r[NPROD_W-1:16];
  assign nq_s    = nneg_r ? -$signed({7'b0, nq}) : $signed({7'b0, nq});
  assign noisy_w = $signed({{(SAT_IN_W-SAMPLE_W){clean[SAMPLE_W-1]}}, clean}) + nq_s;

  assign held_clean = held_clean_r;
  assign held_noisy = held_noisy_r;

endmodule

// ----- rtl/vre_level.sv -----
// Block level meter: clamped magnitude accumulator and restoring divider for the average.
// Depends on vre_pkg.
module vre_level
  import vre_pkg::*;
#(
  parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int LEVEL_CLAMP = LEVEL_CLAMP_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 acc_en,
  input  logic [$clog2(LEVEL_CLAMP+1)-1:0]     mag,
  input  logic                                 last,
  input  logic                                 lvl_en,
  output logic                                 busy,
  output logic [LEVEL_W-1:0]                   level
);

  localparam int MAG_W = $clog2(LEVEL_CLAMP + 1);
  localparam int FC_W  = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W = $clog2(BLOCK_MAX * LEVEL_CLAMP + 1);
  localparam int DEN_W = SUM_W + 1;
  localparam int QBITS = LEVEL_W + 1;
  localparam int CNT_W = $clog2(QBITS);

  lvl_state_t          state_r, state_nxt;
  logic [FC_W-1:0]     fc_r;
  logic [SUM_W-1:0]    sum_r;
  logic [FC_W-1:0]     div_fc_r;
  logic [DEN_W-1:0]    den_r;
  logic [DEN_W-1:0]    rem_r;
  logic [QBITS-1:0]    q_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [LEVEL_W-1:0]  level_r;

  logic                fc_inc;
  logic [FC_W-1:0]     fc_new;
  logic [SUM_W-1:0]    sum_new;
  logic                ge;
  logic [DEN_W-1:0]    rem_sub;
  logic [QBITS-1:0]    q_nxt;
  logic                start_div;

  assign fc_inc    = fc_r < FC_W'(BLOCK_MAX);
  assign fc_new    = fc_inc ? fc_r + FC_W'(1) : fc_r;
  assign sum_new   = fc_inc ? sum_r + SUM_W'(mag) : sum_r;
  assign start_div = acc_en && last && lvl_en;

  assign ge      = rem_r >= den_r;
  assign rem_sub = ge ? rem_r - den_r : rem_r;
  assign q_nxt   = {q_r[QBITS-2:0], ge};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LV_IDLE: if (start_div) state_nxt = LV_DEN;
      LV_DEN:  state_nxt = LV_RUN;
      LV_RUN:  if (cnt_r == '0) state_nxt = LV_IDLE;
      default: state_nxt = LV_IDLE;
    endcase
  end

  assign busy  = (state_r != LV_IDLE);
  assign level = level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LV_IDLE;
      fc_r    <= '0;
      sum_r   <= '0;
      level_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (acc_en) begin
        if (last) begin
          fc_r  <= '0;
          sum_r <= '0;
        end else begin
          fc_r  <= fc_new;
          sum_r <= sum_new;
        end
        if (!start_div) begin
          level_r <= '0;
        end
      end
      // quotient tops out at exactly one full scale; saturate it
      if (state_r == LV_RUN && cnt_r == '0) begin
        level_r <= q_nxt[QBITS-1] ? {LEVEL_W{1'b1}} : q_nxt[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      div_fc_r <= fc_new;
      rem_r    <= {1'b0, sum_new};
    end
    case (state_r)
      LV_DEN: begin
        den_r <= DEN_W'(div_fc_r) * DEN_W'(LEVEL_CLAMP);
        q_r   <= '0;
        cnt_r <= CNT_W'(QBITS - 1);
      end
      LV_RUN: begin
        q_r   <= q_nxt;
        rem_r <= {rem_sub[DEN_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- tb/sv/voice_effect_checker.sv -----
// Frame checker for the voice radio effect block: watches the request, result and register
// channels, predicts each frame's result and compares it field by field.
// Depends on vre_pkg for widths, modes, register indexes and LFSR constants.
module voice_effect_checker
  import vre_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_left,
  input  logic signed [SAMPLE_W-1:0] in_sample_right,
  input  logic                       in_block_end,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] out_left,
  input  logic signed [SAMPLE_W-1:0] out_right,
  input  logic [LEVEL_W-1:0]         out_level,
  input  logic                       out_block_last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         mismatch_count,
  output int                         pending_frames
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEVEL_CLAMP = LEVEL_CLAMP_DEF;
  localparam int BLOCK_MAX   = BLOCK_MAX_DEF;
  localparam int MAX_CHANS   = MAX_CHANNELS_DEF;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic [LEVEL_W-1:0]         level;
    logic                       last;
  } voice_frame_t;

  voice_frame_t expected_frames[$];
  int           results_seen;

  // register copy
  mode_t               fx_mode;
  logic [CHAN_W-1:0]   chan_cfg;
  logic [GAIN_W-1:0]   client_gain;
  logic [LIMIT_W-1:0]  clip_limit;
  logic [GAIN_W-1:0]   radio_gain;
  logic [GAIN_W-1:0]   noise_gain;
  logic [DS_W-1:0]     ds_factor;

  // effect and meter state
  logic signed [SAMPLE_W-1:0] held_clean;
  logic signed [SAMPLE_W-1:0] held_noisy;
  logic [7:0]                 group_phase;
  logic [12:0]                frame_count;
  logic [22:0]                level_sum;
  logic [LFSR_W-1:0]          noise_lfsr;

  function automatic longint scale_toward_zero(input longint x, input longint f, input int sh);
    longint m;
    m = ((x < 0) ? -x : x) * f;
    m = m >> sh;
    return (x < 0) ? -m : m;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(input longint v);
    longint c;
    c = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
    return c[SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    case (reg_idx_t'(idx))
      REG_MODE:             fx_mode = mode_t'(data[1:0]);
      REG_CHANNEL_COUNT:    chan_cfg = data[CHAN_W-1:0];
      REG_CLIENT_GAIN:      client_gain = data;
      REG_DISTORTION_LIMIT: clip_limit = data[LIMIT_W-1:0];
      REG_RADIO_GAIN:       radio_gain = data;
      REG_NOISE_GAIN:       noise_gain = data;
      REG_DOWNSAMPLE:       ds_factor = data[DS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_voice_frame(input logic signed [SAMPLE_W-1:0] xl_in,
                                     input logic signed [SAMPLE_W-1:0] xr_in,
                                     input logic last, output voice_frame_t r);
    int     chans;
    int     factor;
    bit     gain_ok;
    longint xl;
    longint xr;
    longint ol;
    longint orr;
    longint lim;
    longint clipped;
    longint mag;
    longint q;
    xl      = longint'(xl_in);
    xr      = longint'(xr_in);
    chans   = (chan_cfg == 0) ? 1 : int'(chan_cfg);
    factor  = (ds_factor == 0) ? 1 : int'(ds_factor);
    gain_ok = (client_gain != 0) && (client_gain <= GAIN_UNITY);
    ol      = xl;
    orr     = xr;
    r.level = '0;
    if (chans > MAX_CHANS) chans = MAX_CHANS;
    // factor lowered mid-group: restart the group
    if (int'(group_phase) >= factor) group_phase = '0;

    if (fx_mode == MODE_MUTE) begin
      ol  = 0;
      orr = 0;
    end else if (fx_mode == MODE_PLAIN && gain_ok) begin
      ol  = longint'(clamp16(scale_toward_zero(xl, longint'(client_gain), 15)));
      orr = longint'(clamp16(scale_toward_zero(xr, longint'(client_gain), 15)));
    end else if (fx_mode == MODE_RADIO && gain_ok) begin
      if (group_phase == 0) begin
        lim     = longint'(clip_limit);
        clipped = (xl > lim) ? lim : ((xl < -lim) ? -lim : xl);
        noise_lfsr = noise_lfsr[0] ? ((noise_lfsr >> 1) ^ LFSR_MASK) : (noise_lfsr >> 1);
        held_clean = clamp16(scale_toward_zero(clipped,
                                               longint'(radio_gain) * longint'(client_gain), 27));
        held_noisy = clamp16(longint'(held_clean) +
                             scale_toward_zero(longint'($signed(noise_lfsr[15:0])),
                                               longint'(noise_gain), 16));
      end
      ol  = longint'(group_phase[0] ? held_noisy : held_clean);
      orr = ol;
    end
    if (chans < 2) orr = 0;

    mag = (xl < 0) ? -xl : xl;
    if (mag > LEVEL_CLAMP) mag = longint'(LEVEL_CLAMP);
    if (frame_count < BLOCK_MAX) begin
      frame_count++;
      level_sum += mag[22:0];
    end

    if (int'(group_phase) + 1 >= factor) group_phase = '0;
    else group_phase++;

    if (last) begin
      if ((fx_mode == MODE_PLAIN || fx_mode == MODE_RADIO) && gain_ok && frame_count != 0) begin
        q = (longint'(level_sum) << 16) / (longint'(frame_count) * LEVEL_CLAMP);
        r.level = (q > 65535) ? 16'hFFFF : q[LEVEL_W-1:0];
      end
      frame_count = '0;
      level_sum   = '0;
      group_phase = '0;
    end

    r.left  = ol[SAMPLE_W-1:0];
    r.right = orr[SAMPLE_W-1:0];
    r.last  = last;
  endtask

  always @(posedge clk) begin : monitor
    voice_frame_t got;
    voice_frame_t want;
    voice_frame_t predicted;
    if (!rst_n) begin
      fx_mode        = MODE_PASS;
      chan_cfg       = 2'd1;
      client_gain    = GAIN_UNITY;
      clip_limit     = 15'h7FFF;
      radio_gain     = 16'd4096;
      noise_gain     = '0;
      ds_factor      = 8'd1;
      held_clean     = '0;
      held_noisy     = '0;
      group_phase    = '0;
      frame_count    = '0;
      level_sum      = '0;
      noise_lfsr     = LFSR_SEED;
      mismatch_count = 0;
      results_seen   = 0;
      expected_frames.delete();
      pending_frames <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      // retire before predicting: a request taken this edge cannot already have a result
      if (out_valid && out_ready) begin
        got = '{out_left, out_right, out_level, out_block_last};
        if (expected_frames.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_frames.pop_front();
          if (got.left !== want.left)
            report_mismatch($sformatf("result %0d left %0d, expected %0d",
                                      results_seen, got.left, want.left));
          if (got.right !== want.right)
            report_mismatch($sformatf("result %0d right %0d, expected %0d",
                                      results_seen, got.right, want.right));
          if (got.level !== want.level)
            report_mismatch($sformatf("result %0d level %0d, expected %0d",
                                      results_seen, got.level, want.level));
          if (got.last !== want.last)
            report_mismatch($sformatf("result %0d block_last %b, expected %b",
                                      results_seen, got.last, want.last));
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        predict_voice_frame(in_sample_left, in_sample_right, in_block_end, predicted);
        expected_frames.push_back(predicted);
      end
      pending_frames <= expected_frames.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the voice radio effect testbench: clock, reset, request and register stimulus,
// result-side stalls and the final verdict. Depends on vre_pkg, the block top and
// voice_effect_checker, which does all prediction and comparison.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vre_pkg::*;

  localparam int CLK_PERIOD        = 10;
  localparam int RANDOM_FRAMES     = 1100;
  localparam int LONG_HOLD         = 400;
  localparam int DRAIN_CYCLES      = 40;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;

  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_style_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_left;
  logic signed [SAMPLE_W-1:0] in_sample_right;
  logic                       in_block_end;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic [LEVEL_W-1:0]         out_level;
  logic                       out_block_last;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  int                         mismatch_count;
  int                         pending_frames;

  int        frames_sent = 0;
  int        burst_left  = 0;
  int        max_gap     = 12;
  int        block_left  = 0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;
  rx_style_t rx_style;
  int        rx_span;
  int        rx_tick     = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  voice_radio_effect_level_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_block_end    (in_block_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_level       (out_level),
    .out_block_last  (out_block_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  voice_effect_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_left  (in_sample_left),
    .in_sample_right (in_sample_right),
    .in_block_end    (in_block_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left        (out_left),
    .out_right       (out_right),
    .out_level       (out_level),
    .out_block_last  (out_block_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .pending_frames  (pending_frames)
  );

  // Offer one frame; bursts of requests are separated by random idle gaps.
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, max_gap);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample_left  <= left;
    in_sample_right <= right;
    in_block_end    <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    frames_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and let every outstanding result come back before touching registers.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_frames != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = -32768;
      1: v = 32767;
      2: begin
        v = $urandom_range(1799, 1801);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: v = 0;
      4, 5, 6: v = $urandom_range(0, 65535);
      default: v = int'($urandom_range(0, 5000)) - 2500;
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic int pick_block_len();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom_range(250, 300);
    if (sel <= 5) return $urandom_range(9, 60);
    return $urandom_range(1, 8);
  endfunction

  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] junk;
    logic [1:0]            mode_bits;
    logic [CFG_DATA_W-1:0] value;
    // occasionally set bits above the register width
    junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
    case ($urandom_range(0, 9))
      0:          mode_bits = MODE_PASS;
      1:          mode_bits = MODE_MUTE;
      2, 3, 4, 5: mode_bits = MODE_PLAIN;
      default:    mode_bits = MODE_RADIO;
    endcase
    write_reg(REG_MODE, {junk[CFG_DATA_W-1:2], mode_bits});
    write_reg(REG_CHANNEL_COUNT, {junk[CFG_DATA_W-1:2], 2'($urandom_range(0, 3))});
    case ($urandom_range(0, 7))
      0:       value = '0;
      1:       value = GAIN_UNITY;
      2:       value = CFG_DATA_W'($urandom_range(32769, 65535));
      3:       value = 16'd1;
      default: value = CFG_DATA_W'($urandom_range(1, 32768));
    endcase
    write_reg(REG_CLIENT_GAIN, value);
    case ($urandom_range(0, 3))
      0:       value = {junk[CFG_DATA_W-1], 15'd0};
      1:       value = {junk[CFG_DATA_W-1], 15'h7FFF};
      default: value = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    write_reg(REG_DISTORTION_LIMIT, value);
    case ($urandom_range(0, 4))
      0:       value = '0;
      1:       value = 16'hFFFF;
      2:       value = 16'd4096;
      default: value = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    write_reg(REG_RADIO_GAIN, value);
    case ($urandom_range(0, 3))
      0:       value = '0;
      1:       value = 16'hFFFF;
      default: value = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    write_reg(REG_NOISE_GAIN, value);
    case ($urandom_range(0, 4))
      0:       value = 16'd0;
      1:       value = 16'd1;
      2:       value = 16'd255;
      default: value = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    write_reg(REG_DOWNSAMPLE, {junk[CFG_DATA_W-1:DS_W], value[DS_W-1:0]});
  endtask

  // Result side: stall on shifting patterns, with one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_span  = $urandom_range(8, 120);
      repeat (rx_span) begin
        @(negedge clk);
        rx_tick++;
        if (hold_req && !hold_done) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD - 1) @(negedge clk);
          hold_done = 1'b1;
        end else begin
          case (rx_style)
            RX_ALWAYS: out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= (rx_tick % 3 == 0);
          endcase
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int phase_idx;
    int phase_len;
    bit noisy;
    logic last;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_left  = '0;
    in_sample_right = '0;
    in_block_end    = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pass-through at reset settings, one channel
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 16'd2);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_MUTE));
    send_frame(16'sd1234, -16'sd1234, 1'b1);
    wait_idle();
    // plain gain at unity; a one-frame loud block saturates the level
    write_reg(REG_MODE, CFG_DATA_W'(MODE_PLAIN));
    send_frame(16'sh8000, 16'sh7FFF, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sd0, 16'sd0, 1'b1);
    send_frame(16'sh8000, -16'sd1, 1'b1);
    wait_idle();
    write_reg(REG_CLIENT_GAIN, 16'd1);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    wait_idle();
    // gain outside the unity range passes frames unchanged
    write_reg(REG_CLIENT_GAIN, 16'd0);
    send_frame(16'sd1000, -16'sd1000, 1'b1);
    wait_idle();
    write_reg(REG_CLIENT_GAIN, 16'hFFFF);
    send_frame(-16'sd5, 16'sd5, 1'b1);
    wait_idle();
    // radio with factor zero, maximum gains
    write_reg(REG_CLIENT_GAIN, GAIN_UNITY);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_RADIO));
    write_reg(REG_RADIO_GAIN, 16'hFFFF);
    write_reg(REG_NOISE_GAIN, 16'hFFFF);
    write_reg(REG_DOWNSAMPLE, 16'd0);
    send_frame(16'sh7FFF, 16'sd5, 1'b0);
    send_frame(16'sh8000, 16'sd5, 1'b0);
    send_frame(16'sd100, 16'sd5, 1'b1);
    wait_idle();
    // zero clip limit, three channels, then lower the factor mid-group
    write_reg(REG_DOWNSAMPLE, 16'd4);
    write_reg(REG_DISTORTION_LIMIT, 16'd0);
    write_reg(REG_CHANNEL_COUNT, 16'd3);
    send_frame(16'sd20000, 16'sd1, 1'b0);
    send_frame(-16'sd20000, 16'sd1, 1'b0);
    send_frame(16'sd7, 16'sd1, 1'b0);
    wait_idle();
    write_reg(REG_DOWNSAMPLE, 16'd2);
    send_frame(-16'sd300, 16'sd2, 1'b0);
    send_frame(16'sd300, 16'sd2, 1'b1);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, 16'd0);
    write_reg(REG_DISTORTION_LIMIT, 16'd1000);
    write_reg(REG_RADIO_GAIN, 16'd4096);
    write_reg(REG_NOISE_GAIN, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_frame(-16'sd2000, 16'sd9, 1'b0);
    send_frame(16'sd2000, 16'sd9, 1'b1);

    // random phases of well-formed blocks, some with scattered block ends
    phase_idx = 0;
    while (frames_sent < RANDOM_FRAMES) begin
      wait_idle();
      pick_settings();
      phase_len = $urandom_range(20, 80);
      noisy     = ($urandom_range(0, 4) == 0);
      if (phase_idx == 3) hold_req <= 1'b1;
      repeat (phase_len) begin
        if (noisy) begin
          last = ($urandom_range(0, 3) == 0);
        end else begin
          if (block_left == 0) block_left = pick_block_len();
          block_left--;
          last = (block_left == 0);
        end
        send_frame(pick_sample(), pick_sample(), last);
      end
      phase_idx++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
